// ===== src/dnsle_pkg.sv =====
// dnsle_pkg: constants, command and status types shared by the label encoder
// modules. No dependencies; compiled first.
`default_nettype none

package dnsle_pkg;

  // label buffer geometry
  localparam int LABEL_MAX   = 62;
  localparam int CNT_W       = 6;
  localparam int ADDR_W      = CNT_W + 1;
  localparam int RAM_DEPTH   = 2 ** ADDR_W;
  localparam int QUEUE_DEPTH = 2;

  // special characters
  localparam logic [7:0] CH_DOT = 8'd46;
  localparam logic [7:0] CH_END = 8'd0;

  // what the back end has to emit for one queued command
  typedef enum logic [1:0] {
    CMD_TERM       = 2'd0,
    CMD_FLUSH      = 2'd1,
    CMD_FLUSH_TERM = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CNT_W-1:0]   count;
    logic               bank;
    logic               ovf;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  // back end hands a label bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

endpackage

`default_nettype wire

// ===== src/dnsle_if.sv =====
// dnsle_if: valid/ready channel interfaces for name characters and wire bytes.
// No dependencies.
`default_nettype none

interface byte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       too_long;

  modport source (output valid, output out_byte, output last, output too_long, input ready);
  modport sink   (input valid, input out_byte, input last, input too_long, output ready);
endinterface

`default_nettype wire

// ===== src/dnsle_ram.sv =====
// dnsle_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
`default_nettype none

module dnsle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/dnsle_front.sv =====
// dnsle_front: accepts name characters, buffers labels into two RAM banks and
// queues emit commands. Depends on dnsle_pkg and dnsle_if.
`default_nettype none

module dnsle_front (
  input  wire logic                clk,
  input  wire logic                rst,
  byte_in_if.sink                  name_in,
  output dnsle_pkg::push_t         push,
  input  wire logic                q_full,
  input  wire dnsle_pkg::release_t rel,
  output dnsle_pkg::ram_wr_t       wr
);
  import dnsle_pkg::*;

  logic [CNT_W-1:0] count, count_next;
  logic             wbank, wbank_next;
  logic             closed, closed_next;
  logic             overflow, overflow_next;
  logic [1:0]       busy, busy_next;
  logic             ready;
  logic             is_dot, is_end;

  assign is_dot = (name_in.in_byte == CH_DOT);
  assign is_end = (name_in.in_byte == CH_END);
  assign name_in.ready = ready;

  // classify the incoming character
  always_comb begin
    count_next    = count;
    wbank_next    = wbank;
    closed_next   = closed;
    overflow_next = overflow;
    busy_next     = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    ready    = 1'b0;
    push     = '0;
    wr       = '0;
    push.cmd.kind = CMD_TERM;

    if (closed) begin
      // waiting for the end of a cut-short name
      ready = 1'b1;
      if (name_in.valid && is_end) begin
        closed_next = 1'b0;
      end
    end else if (is_dot || is_end) begin
      ready = !q_full;
      if (name_in.valid && ready) begin
        push.valid     = 1'b1;
        push.cmd.ovf   = overflow;
        push.cmd.bank  = wbank;
        push.cmd.count = count;
        if (count == '0) begin
          push.cmd.kind = CMD_TERM;
          if (is_dot) begin
            closed_next = 1'b1;
          end
        end else begin
          push.cmd.kind    = is_dot ? CMD_FLUSH : CMD_FLUSH_TERM;
          busy_next[wbank] = 1'b1;
          wbank_next       = ~wbank;
          count_next       = '0;
        end
      end
    end else if (count < CNT_W'(LABEL_MAX)) begin
      // ordinary character into the current bank
      ready = !busy[wbank];
      if (name_in.valid && ready) begin
        wr.we      = 1'b1;
        wr.addr    = {wbank, count};
        wr.data    = name_in.in_byte;
        count_next = count + CNT_W'(1);
      end
    end else begin
      // label full: drop and flag
      ready = 1'b1;
      if (name_in.valid) begin
        overflow_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      wbank    <= 1'b0;
      closed   <= 1'b0;
      overflow <= 1'b0;
      busy     <= '0;
    end else begin
      count    <= count_next;
      wbank    <= wbank_next;
      closed   <= closed_next;
      overflow <= overflow_next;
      busy     <= busy_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/dnsle_cmd_queue.sv =====
// dnsle_cmd_queue: short command queue between front and back end.
// Depends on dnsle_pkg.
`default_nettype none

module dnsle_cmd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dnsle_pkg::push_t push,
  output logic                  full,
  input  wire logic             pop,
  output dnsle_pkg::cmd_t       head,
  output logic                  not_empty
);
  import dnsle_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr, rptr;
  logic [CNT_QW-1:0] fill;
  logic              do_push, do_pop;

  assign full      = (fill == CNT_QW'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push.cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_QW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/dnsle_back.sv =====
// dnsle_back: executes queued commands, reading label bytes from RAM and
// driving the output register. Depends on dnsle_pkg and dnsle_if.
`default_nettype none

module dnsle_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dnsle_pkg::cmd_t       head,
  input  wire logic                  not_empty,
  output logic                       pop,
  output dnsle_pkg::release_t        rel,
  output logic [dnsle_pkg::ADDR_W-1:0] raddr,
  input  wire logic [7:0]            rdata,
  enc_out_if.source                  wire_out
);
  import dnsle_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_LEN  = 4'b0010,
    B_DATA = 4'b0100,
    B_TERM = 4'b1000
  } back_state_t;

  back_state_t      state, state_next;
  cmd_t             cur, cur_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             slot_free;
  logic             load;
  logic [7:0]       load_byte;
  logic             load_last;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_last;
  logic             out_ovf;

  assign slot_free = !out_valid || wire_out.ready;

  // sequencer over one command
  always_comb begin
    state_next = state;
    cur_next   = cur;
    idx_next   = idx;
    pop        = 1'b0;
    rel        = '0;
    load       = 1'b0;
    load_byte  = '0;
    load_last  = 1'b0;
    case (state)
      B_IDLE: begin
        if (not_empty) begin
          pop        = 1'b1;
          cur_next   = head;
          idx_next   = '0;
          state_next = (head.kind == CMD_TERM) ? B_TERM : B_LEN;
        end
      end
      B_LEN: begin
        if (slot_free) begin
          load       = 1'b1;
          load_byte  = 8'(cur.count);
          state_next = B_DATA;
        end
      end
      B_DATA: begin
        if (slot_free) begin
          load      = 1'b1;
          load_byte = rdata;
          if (idx == cur.count - CNT_W'(1)) begin
            rel.valid  = 1'b1;
            rel.bank   = cur.bank;
            state_next = (cur.kind == CMD_FLUSH_TERM) ? B_TERM : B_IDLE;
          end else begin
            idx_next = idx + CNT_W'(1);
          end
        end
      end
      B_TERM: begin
        if (slot_free) begin
          load       = 1'b1;
          load_byte  = CH_END;
          load_last  = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // read address follows the next index so the registered read data lines up with idx
  assign raddr = {cur_next.bank, idx_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    idx <= idx_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (wire_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= load_byte;
      out_last <= load_last;
      out_ovf  <= cur.ovf;
    end
  end

  assign wire_out.valid    = out_valid;
  assign wire_out.out_byte = out_byte;
  assign wire_out.last     = out_last;
  assign wire_out.too_long = out_ovf;

  // checks
  a_last_is_zero: assert property (@(posedge clk) disable iff (rst)
    wire_out.valid && wire_out.last |-> wire_out.out_byte == '0)
    else $error("terminator byte not zero");

  a_idx_in_label: assert property (@(posedge clk) disable iff (rst)
    state == B_DATA |-> idx < cur.count)
    else $error("label index past label length");

  a_release_on_last: assert property (@(posedge clk) disable iff (rst)
    rel.valid |-> state == B_DATA && slot_free)
    else $error("bank released outside data emission");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != B_IDLE)
    else $error("command popped but sequencer stayed idle");

endmodule

`default_nettype wire

// ===== src/dns_name_label_encoder.sv =====
// dns_name_label_encoder: top level, dotted name in, length-prefixed labels out.
// Depends on dnsle_pkg, dnsle_if, dnsle_ram, dnsle_front, dnsle_cmd_queue,
// dnsle_back.
//
//   channel    dir   handshake     payload
//   name_in    in    valid/ready   in_byte[7:0]
//   wire_out   out   valid/ready   out_byte[7:0], last, too_long
//
// A name character is taken while ready is high; a label of n characters
// leaves as n+1 bytes, one per cycle while wire_out is ready, and the
// terminator as one more; the back end takes each command off the queue in
// its idle state, emitting no byte; all bytes pass the single output register.
// Two label banks in RAM let the next label fill while the previous drains;
// a character waits while its bank still drains, a dot or end byte while the
// queue is full. Reset is synchronous; the label RAM needs no clearing pass.
// Output stalls back up through a two-entry command queue to name_in.
`default_nettype none

module dns_name_label_encoder (
  input  wire logic clk,
  input  wire logic rst,
  byte_in_if.sink   name_in,
  enc_out_if.source wire_out
);
  import dnsle_pkg::*;

  push_t             push;
  logic              q_full;
  logic              pop;
  cmd_t              head;
  logic              not_empty;
  release_t          rel;
  ram_wr_t           wr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  dnsle_front u_front (
    .clk     (clk),
    .rst     (rst),
    .name_in (name_in),
    .push    (push),
    .q_full  (q_full),
    .rel     (rel),
    .wr      (wr)
  );

  dnsle_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  dnsle_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_label_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  dnsle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .rel       (rel),
    .raddr     (raddr),
    .rdata     (rdata),
    .wire_out  (wire_out)
  );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for dns_name_label_encoder, feeding dotted names and
// checking each encoded wire byte against a cycle-free label predictor.
// Depends on dnsle_pkg, dnsle_if and the encoder RTL.
`timescale 1ns / 100ps

module tb_top;
  import dnsle_pkg::*;

  localparam int DRAIN_GAP   = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 10;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic [7:0] octet;
    logic       lst;
    logic       tl;
  } wire_byte_t;

  logic clk = 1'b0;
  logic rst;

  byte_in_if name_in_ch ();
  enc_out_if wire_out_ch ();

  dns_name_label_encoder uut (
    .clk      (clk),
    .rst      (rst),
    .name_in  (name_in_ch),
    .wire_out (wire_out_ch)
  );

  // label predictor state
  logic [7:0]  lbl_buf [LABEL_MAX];
  int unsigned lbl_len;
  bit          name_cut;
  bit          ovf_sticky;
  wire_byte_t  wire_q [$];

  int unsigned err_count;
  int unsigned chars_sent;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          hold_req;
  int unsigned hold_left;

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void queue_wire_byte(input logic [7:0] b, input logic lst);
    wire_byte_t wb;
    wb.octet = b;
    wb.lst   = lst;
    wb.tl    = ovf_sticky;
    wire_q.insert(wire_q.size(), wb);
  endfunction

  // length byte then the buffered characters
  function automatic void flush_label_bytes();
    queue_wire_byte(lbl_len[7:0], 1'b0);
    for (int i = 0; i < lbl_len; i++) queue_wire_byte(lbl_buf[i], 1'b0);
    lbl_len = 0;
  endfunction

  // expected wire bytes for one accepted name character
  function automatic void predict_encoding(input logic [7:0] c);
    if (name_cut) begin
      if (c == CH_END) name_cut = 1'b0;
    end else if (c == CH_DOT) begin
      if (lbl_len == 0) begin
        queue_wire_byte(CH_END, 1'b1);
        name_cut = 1'b1;
      end else begin
        flush_label_bytes();
      end
    end else if (c == CH_END) begin
      if (lbl_len != 0) flush_label_bytes();
      queue_wire_byte(CH_END, 1'b1);
    end else if (lbl_len < LABEL_MAX) begin
      lbl_buf[lbl_len] = c;
      lbl_len++;
    end else begin
      ovf_sticky = 1'b1;
    end
  endfunction

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_DOT);
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(7))
      0: return CH_END;
      1: return CH_DOT;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one name character, with random sender gaps
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < snd_idle_pct) begin
      name_in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    name_in_ch.valid   <= 1'b1;
    name_in_ch.in_byte <= c;
    do @(posedge clk); while (!name_in_ch.ready);
    predict_encoding(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  // sender stops until every expected byte is out, then lets the tail settle
  task automatic drain_results();
    name_in_ch.valid <= 1'b0;
    while (wire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // mostly well-formed names, some broken by empty labels, some raw noise
  task automatic send_random_name(input int unsigned max_label);
    int unsigned kind;
    int unsigned nlab;
    int unsigned len;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 8)) send_char(noise_char());
    end else begin
      nlab = $urandom_range(1, 4);
      if (kind >= 94) send_char(CH_DOT);
      for (int l = 0; l < nlab; l++) begin
        if (l != 0) send_char(CH_DOT);
        len = ($urandom_range(7) == 0) ? $urandom_range(1, max_label) : $urandom_range(1, 8);
        repeat (len) send_char(label_char());
        if (kind >= 88 && $urandom_range(1) == 1) send_char(CH_DOT);
      end
      if ($urandom_range(4) == 0) send_char(CH_DOT);
      send_char(CH_END);
    end
  endtask

  task automatic test_basic_names();
    send_text("ab.c");
    send_char(CH_END);
    send_char(CH_END);
    send_text("x.");
    send_char(CH_END);
  endtask

  // leading dot and double dot close the name until its end byte
  task automatic test_empty_labels();
    send_text(".q.");
    send_char(CH_END);
    send_text("a..b");
    send_char(CH_END);
  endtask

  task automatic test_high_bytes();
    send_char(8'hFF);
    send_char(8'h80);
    send_char(8'h01);
    send_char(8'h7F);
    send_char(CH_END);
    drain_results();
  endtask

  task automatic test_random_names(input int unsigned snd_pct, input int unsigned rcv_pct);
    int unsigned start;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    start = chars_sent;
    while (chars_sent - start < RAND_ITEMS) send_random_name(40);
    drain_results();
  endtask

  task automatic test_full_label();
    repeat (LABEL_MAX) send_char(label_char());
    send_char(CH_END);
    drain_results();
  endtask

  // receiver holds off while several labels queue up behind it
  task automatic test_output_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req = 1'b1;
    for (int l = 0; l < 5; l++) begin
      if (l != 0) send_char(CH_DOT);
      repeat (10) send_char(label_char());
    end
    send_char(CH_END);
    drain_results();
  endtask

  // overflow is sticky, so this runs last
  task automatic test_label_overflow();
    int unsigned start;
    snd_idle_pct = 30;
    rcv_idle_pct = 30;
    repeat (LABEL_MAX + 3) send_char(label_char());
    send_char(CH_DOT);
    send_text("ok");
    send_char(CH_END);
    start = chars_sent;
    while (chars_sent - start < 5) send_random_name(12);
    drain_results();
  endtask

  // output side: check each transaction, then decide ready for the next cycle
  always @(posedge clk) begin
    wire_byte_t want;
    if (!rst && wire_out_ch.valid && wire_out_ch.ready) begin
      if (wire_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %0d last %0b too_long %0b",
                                  wire_out_ch.out_byte, wire_out_ch.last,
                                  wire_out_ch.too_long));
      end else begin
        want = wire_q.pop_front();
        if (wire_out_ch.out_byte !== want.octet)
          report_mismatch($sformatf("out_byte %0d, expected %0d",
                                    wire_out_ch.out_byte, want.octet));
        if (wire_out_ch.last !== want.lst)
          report_mismatch($sformatf("last %0b, expected %0b", wire_out_ch.last, want.lst));
        if (wire_out_ch.too_long !== want.tl)
          report_mismatch($sformatf("too_long %0b, expected %0b",
                                    wire_out_ch.too_long, want.tl));
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      wire_out_ch.ready <= 1'b0;
    end else begin
      wire_out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // run limit
  initial begin
    #1_000_000;
    $display("FAIL dns_name_label_encoder");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    name_in_ch.valid    = 1'b0;
    name_in_ch.in_byte  = '0;
    wire_out_ch.ready   = 1'b0;
    hold_req            = 1'b0;
    hold_left           = 0;
    err_count           = 0;
    chars_sent          = 0;
    snd_idle_pct        = 17;
    rcv_idle_pct        = 66;
    lbl_len             = 0;
    name_cut            = 1'b0;
    ovf_sticky          = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_basic_names();
    test_empty_labels();
    test_high_bytes();
    test_random_names(17, 66);
    test_random_names(66, 17);
    test_full_label();
    test_random_names(0, 0);
    test_output_backpressure();
    test_label_overflow();

    if (err_count == 0) begin
      $display("PASS dns_name_label_encoder");
    end else begin
      $display("FAIL dns_name_label_encoder");
    end
    $finish;
  end

endmodule
